// File: hdl/multipass_average_pool_clamp_top_defines.svh
// Assertion macros used by the checker file of the pooling block.
// No dependencies.
`ifndef MULTIPASS_AVERAGE_POOL_CLAMP_TOP_DEFINES_SVH
`define MULTIPASS_AVERAGE_POOL_CLAMP_TOP_DEFINES_SVH

// clocked check, masked while reset is asserted
`define MPAC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MPAC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mpac_pkg.sv
// Shared constants, types and helpers of the average pooling block.
// No dependencies.
`timescale 1ns / 1ps

package mpac_pkg;

  localparam int unsigned CHANNELS_DEF = 256;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [WORD_W-1:0] QNAN    = 32'h7FC0_0000;
  localparam logic [WORD_W-1:0] NEG_INF = 32'hFF80_0000;
  localparam logic [WORD_W-1:0] POS_INF = 32'h7F80_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_MIN = 1'b0,
    CFG_OUTPUT_MAX = 1'b1
  } cfg_idx_e;

  // finished window sum handed from the accumulator to the scaler
  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] scale;
    logic [CH_W-1:0]   ch;
  } acc_word_t;

  // leading zero count, 48 when the word is zero
  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage

// File: hdl/mpac_if.sv
// Valid/ready channel interfaces for the pooling block input and result words.
// Depends on mpac_pkg.
`timescale 1ns / 1ps

interface mpac_in_if import mpac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] sample_bits;
  logic [CH_W-1:0]   channel_index;
  logic              first_row;
  logic              last_row;
  logic [WORD_W-1:0] scale_bits;

  modport source (output valid, sample_bits, channel_index, first_row, last_row, scale_bits,
                  input ready);
  modport sink (input valid, sample_bits, channel_index, first_row, last_row, scale_bits,
                output ready);
endinterface

interface mpac_out_if import mpac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] average_bits;
  logic [CH_W-1:0]   out_channel;

  modport source (output valid, average_bits, out_channel, input ready);
  modport sink (input valid, average_bits, out_channel, output ready);
endinterface

// File: hdl/multipass_average_pool_clamp_top.sv
// Per-channel average pooling with clamp, binary32.
// Input words (in_i) carry one channel value of one window row; a first-row
// word overwrites the channel's accumulator, other rows add to it in arrival
// order. A last-row word yields one result word on out_o: sum times the
// word's scale, clamped to [output_min, output_max], NaN made canonical.
// Words for a channel at or beyond CHANNELS are taken and dropped.
// Bounds are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// Throughput: one word per cycle. A word for a channel still in the three
// add stages waits until that entry is written back, since the sum store
// is read when the word is accepted and written back from the third stage.
// Every stage holds under backpressure and empty stages close up, so input
// is still taken while a result waits on out_o, until the pipe is full.
// Reset: valids cleared, bounds return to -inf/+inf; the sum store is not
// cleared, each window begins with a first-row word.
// Depends on mpac_pkg, mpac_if, mpac_accum, mpac_scale.
`timescale 1ns / 1ps

module multipass_average_pool_clamp_top import mpac_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mpac_in_if.sink              in_i,
  mpac_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  acc_word_t acc;
  logic      acc_valid, acc_ready;

  mpac_accum #(.CHANNELS(CHANNELS)) u_mpac_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .acc_o       (acc),
    .acc_valid_o (acc_valid),
    .acc_ready_i (acc_ready)
  );

  mpac_scale u_mpac_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .acc_valid_i (acc_valid),
    .acc_ready_o (acc_ready),
    .out_o       (out_o)
  );

endmodule

// File: hdl/mpac_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mpac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/mpac_accum.sv
// Accumulator pipeline: channel store read, binary32 add over three stages,
// write back. Depends on mpac_pkg, mpac_if and mpac_ram.
`timescale 1ns / 1ps

module mpac_accum import mpac_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpac_in_if.sink    in_i,
  output acc_word_t  acc_o,
  output logic       acc_valid_o,
  input  logic       acc_ready_i
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic in_range, hazard, accept;
  logic rdy1, rdy2, rdy3;
  logic [WORD_W-1:0] rdata;

  // stage 1: store data arrives
  logic              v1_q, first1_q, last1_q;
  logic [CH_W-1:0]   ch1_q;
  logic [WORD_W-1:0] smp1_q, scl1_q;
  // stage 2: aligned operands
  logic              v2_q, last2_q, sign2_q, sub2_q, spec2_q;
  logic [CH_W-1:0]   ch2_q;
  logic [WORD_W-1:0] scl2_q, specb2_q;
  logic [7:0]        exp2_q;
  logic [26:0]       bm2_q, sm2_q;
  // stage 3: raw sum
  logic              v3_q, last3_q, sgn3_q, spec3_q;
  logic [CH_W-1:0]   ch3_q;
  logic [WORD_W-1:0] scl3_q, specb3_q;
  logic [7:0]        exp3_q;
  logic [27:0]       sum3_q;
  logic [4:0]        lz3_q;

  assign in_range = (32'(in_i.channel_index) < CHANNELS);
  // same channel still in flight: wait until it is written back
  assign hazard = (v1_q && ch1_q == in_i.channel_index) ||
                  (v2_q && ch2_q == in_i.channel_index) ||
                  (v3_q && ch3_q == in_i.channel_index);

  assign rdy3 = !v3_q || !last3_q || acc_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1 && !hazard;
  assign accept = in_i.valid && in_i.ready;

  logic [WORD_W-1:0] sum_bits;

  mpac_ram #(.WIDTH(WORD_W), .DEPTH(CHANNELS)) u_mpac_ram (
    .clk_i   (clk_i),
    .we_i    (v3_q && rdy3),
    .waddr_i (AW'(ch3_q)),
    .wdata_i (sum_bits),
    .re_i    (accept && in_range),
    .raddr_i (AW'(in_i.channel_index)),
    .rdata_o (rdata)
  );

  // ---- alignment
  logic [WORD_W-1:0] opa, opb, big, sml;
  logic              a_nan, b_nan, a_inf, b_inf, swap;
  logic [7:0]        be, se, d;
  logic [5:0]        dc;
  logic [23:0]       bm, sm;
  logic [49:0]       wide;
  logic [26:0]       sal;
  logic              spec_a;
  logic [WORD_W-1:0] specb_a;

  always_comb begin
    opa   = rdata;
    opb   = smp1_q;
    a_nan = (&opa[30:23]) && (|opa[22:0]);
    b_nan = (&opb[30:23]) && (|opb[22:0]);
    a_inf = (&opa[30:23]) && !(|opa[22:0]);
    b_inf = (&opb[30:23]) && !(|opb[22:0]);
    swap  = opb[30:0] > opa[30:0];
    big   = swap ? opb : opa;
    sml   = swap ? opa : opb;
    be    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    se    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    bm    = {|big[30:23], big[22:0]};
    sm    = {|sml[30:23], sml[22:0]};
    d     = be - se;
    dc    = (d > 8'd50) ? 6'd50 : d[5:0];
    wide  = {sm, 26'd0} >> dc;
    sal   = {wide[49:24], |wide[23:0]};
    spec_a  = 1'b1;
    specb_a = big;
    if (first1_q) begin
      specb_a = smp1_q;
    end else if (a_nan || b_nan || (a_inf && b_inf && (opa[31] != opb[31]))) begin
      specb_a = QNAN;
    end else if (!(a_inf || b_inf)) begin
      spec_a = 1'b0;
    end
  end

  // ---- add and leading zero count
  logic [27:0] sum_b;
  logic [4:0]  lz_b;
  logic        sgn_b;

  always_comb begin
    sum_b = sub2_q ? ({1'b0, bm2_q} - {1'b0, sm2_q}) : ({1'b0, bm2_q} + {1'b0, sm2_q});
    lz_b  = 5'(lzc48({sum_b[26:0], 21'h1F_FFFF}));
    // exact cancellation gives +0
    sgn_b = (sum_b == 28'd0 && sub2_q) ? 1'b0 : sign2_q;
  end

  // ---- normalize and round
  logic [26:0] m;
  logic [8:0]  e9, expf;
  logic [7:0]  lim;
  logic [4:0]  sh;
  logic        up;
  logic [30:0] r31;

  always_comb begin
    lim = exp3_q - 8'd1;
    sh  = ({3'd0, lz3_q} > lim) ? lim[4:0] : lz3_q;
    if (sum3_q[27]) begin
      m  = {sum3_q[27:2], sum3_q[1] | sum3_q[0]};
      e9 = {1'b0, exp3_q} + 9'd1;
    end else begin
      m  = sum3_q[26:0] << sh;
      e9 = {1'b0, exp3_q} - {4'd0, sh};
    end
    expf = m[26] ? e9 : 9'd0;
    up   = m[2] & (m[3] | m[1] | m[0]);
    r31  = {expf[7:0], m[25:3]} + 31'(up);
    if (spec3_q) begin
      sum_bits = specb3_q;
    end else if (expf >= 9'd255) begin
      sum_bits = {sgn3_q, POS_INF[30:0]};
    end else begin
      sum_bits = {sgn3_q, r31};
    end
  end

  assign acc_valid_o = v3_q && last3_q;
  assign acc_o       = '{sum: sum_bits, scale: scl3_q, ch: ch3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept && in_range;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ch1_q    <= in_i.channel_index;
      first1_q <= in_i.first_row;
      last1_q  <= in_i.last_row;
      smp1_q   <= in_i.sample_bits;
      scl1_q   <= in_i.scale_bits;
    end
    if (rdy2) begin
      ch2_q    <= ch1_q;
      last2_q  <= last1_q;
      scl2_q   <= scl1_q;
      sign2_q  <= big[31];
      sub2_q   <= opa[31] ^ opb[31];
      exp2_q   <= be;
      bm2_q    <= {bm, 3'b000};
      sm2_q    <= sal;
      spec2_q  <= spec_a;
      specb2_q <= specb_a;
    end
    if (rdy3) begin
      ch3_q    <= ch2_q;
      last3_q  <= last2_q;
      scl3_q   <= scl2_q;
      sgn3_q   <= sgn_b;
      exp3_q   <= exp2_q;
      sum3_q   <= sum_b;
      lz3_q    <= lz_b;
      spec3_q  <= spec2_q;
      specb3_q <= specb2_q;
    end
  end

endmodule

// File: hdl/mpac_scale.sv
// Scaling pipeline: binary32 multiply, normalize and round, clamp, output
// register; also holds the clamp bound registers. Depends on mpac_pkg, mpac_if.
`timescale 1ns / 1ps

module mpac_scale import mpac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  input  acc_word_t            acc_i,
  input  logic                 acc_valid_i,
  output logic                 acc_ready_o,
  mpac_out_if.source           out_o
);

  logic [WORD_W-1:0] min_q, max_q;

  logic rdy4, rdy5, rdy6, rdy7, rdy8;
  logic v4_q, v5_q, v6_q, v7_q, v8_q;

  logic [WORD_W-1:0] s4_q, c4_q;
  logic [CH_W-1:0]   ch4_q, ch5_q, ch6_q, ch7_q, ch8_q;
  logic [47:0]       p5_q, p6_q;
  logic signed [10:0] t5_q, t6_q;
  logic              sgn5_q, sgn6_q, spec5_q, spec6_q;
  logic [WORD_W-1:0] specb5_q, specb6_q, res7_q, avg8_q;
  logic [5:0]        lz6_q;

  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic an, bn;
    an = (&a[30:23]) && (|a[22:0]);
    bn = (&b[30:23]) && (|b[22:0]);
    if (an || bn) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  assign rdy8 = !v8_q || out_o.ready;
  assign rdy7 = !v7_q || rdy8;
  assign rdy6 = !v6_q || rdy7;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign acc_ready_o = rdy4;

  // ---- multiply
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic [47:0] p_d;
  logic signed [10:0] t_d;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, spec_d, sgn_d;
  logic [WORD_W-1:0] specb_d;

  always_comb begin
    ea     = (s4_q[30:23] == 8'd0) ? 8'd1 : s4_q[30:23];
    eb     = (c4_q[30:23] == 8'd0) ? 8'd1 : c4_q[30:23];
    ma     = {|s4_q[30:23], s4_q[22:0]};
    mb     = {|c4_q[30:23], c4_q[22:0]};
    p_d    = ma * mb;
    t_d    = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
    sgn_d  = s4_q[31] ^ c4_q[31];
    a_nan  = (&s4_q[30:23]) && (|s4_q[22:0]);
    b_nan  = (&c4_q[30:23]) && (|c4_q[22:0]);
    a_inf  = (&s4_q[30:23]) && !(|s4_q[22:0]);
    b_inf  = (&c4_q[30:23]) && !(|c4_q[22:0]);
    a_zero = s4_q[30:0] == 31'd0;
    b_zero = c4_q[30:0] == 31'd0;
    spec_d  = 1'b1;
    specb_d = {sgn_d, POS_INF[30:0]};
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      specb_d = QNAN;
    end else if (!(a_inf || b_inf)) begin
      spec_d = 1'b0;
    end
  end

  // ---- normalize and round the product
  logic signed [10:0] e_n;
  logic [5:0]  sl;
  logic [6:0]  sr;
  logic [8:0]  expf;
  logic [95:0] wide;
  logic [47:0] q;
  logic        st, up;
  logic [30:0] r31;
  logic [WORD_W-1:0] res_d;

  always_comb begin
    e_n = t6_q - $signed({5'd0, lz6_q});
    sl  = 6'd0;
    sr  = 7'd0;
    expf = 9'd0;
    if (e_n >= 11'sd1) begin
      sl   = lz6_q;
      expf = (e_n > 11'sd255) ? 9'd255 : 9'(e_n);
    end else if (t6_q >= 11'sd1) begin
      sl = 6'(t6_q - 11'sd1);
    end else begin
      // deep subnormal: shift right with sticky
      sr = ((11'sd1 - t6_q) > 11'sd96) ? 7'd96 : 7'(11'sd1 - t6_q);
    end
    wide = {p6_q << sl, 48'd0} >> sr;
    q    = wide[95:48];
    st   = |wide[47:0];
    up   = q[23] & (q[24] | (|q[22:0]) | st);
    r31  = {expf[7:0], q[46:24]} + 31'(up);
    if (spec6_q) begin
      res_d = specb6_q;
    end else if (p6_q == 48'd0) begin
      res_d = {sgn6_q, 31'd0};
    end else if (expf >= 9'd255) begin
      res_d = {sgn6_q, POS_INF[30:0]};
    end else begin
      res_d = {sgn6_q, r31};
    end
  end

  // ---- clamp: raise to min, then lower to max
  logic [WORD_W-1:0] clamp_d;

  always_comb begin
    clamp_d = res7_q;
    if (flt_lt(clamp_d, min_q)) clamp_d = min_q;
    if (flt_lt(max_q, clamp_d)) clamp_d = max_q;
  end

  assign out_o.valid        = v8_q;
  assign out_o.average_bits = avg8_q;
  assign out_o.out_channel  = ch8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= NEG_INF;
      max_q <= POS_INF;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_OUTPUT_MIN: min_q <= cfg_data_i;
          CFG_OUTPUT_MAX: max_q <= cfg_data_i;
        endcase
      end
      if (rdy4) v4_q <= acc_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
      if (rdy8) v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_q  <= acc_i.sum;
      c4_q  <= acc_i.scale;
      ch4_q <= acc_i.ch;
    end
    if (rdy5) begin
      p5_q     <= p_d;
      t5_q     <= t_d;
      sgn5_q   <= sgn_d;
      spec5_q  <= spec_d;
      specb5_q <= specb_d;
      ch5_q    <= ch4_q;
    end
    if (rdy6) begin
      p6_q     <= p5_q;
      t6_q     <= t5_q;
      lz6_q    <= lzc48(p5_q);
      sgn6_q   <= sgn5_q;
      spec6_q  <= spec5_q;
      specb6_q <= specb5_q;
      ch6_q    <= ch5_q;
    end
    if (rdy7) begin
      res7_q <= res_d;
      ch7_q  <= ch6_q;
    end
    if (rdy8) begin
      avg8_q <= clamp_d;
      ch8_q  <= ch7_q;
    end
  end

endmodule

// File: hdl/mpac_checker.sv
// Port-level checks on the pooling block result channel, bound to the top.
// Depends on mpac_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "multipass_average_pool_clamp_top_defines.svh"

module mpac_checker import mpac_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [WORD_W-1:0] avg_i,
  input logic [CH_W-1:0]   out_ch_i
);

  `MPAC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(avg_i) && $stable(out_ch_i), "result word changed while stalled")
  `MPAC_ASSERT(a_ch_range, clk_i, rst_ni, out_valid_i |-> (32'(out_ch_i) < CHANNELS), "result for a dropped channel")
  `MPAC_ASSERT(a_nan_canon, clk_i, rst_ni, out_valid_i && (&avg_i[30:23]) && (|avg_i[22:0]) |-> avg_i == QNAN, "non-canonical NaN")
  `MPAC_ASSERT_NR(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind multipass_average_pool_clamp_top mpac_checker #(.CHANNELS(CHANNELS)) u_mpac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .avg_i       (out_o.average_bits),
  .out_ch_i    (out_o.out_channel)
);

// File: sim/tb_top.sv
// Testbench for the per-channel average pooling block with clamp.
// Drives window-row words, predicts the results with a bit-level binary32 model, checks them.
// Depends on mpac_pkg, mpac_if and multipass_average_pool_clamp_top.
`timescale 1ns / 1ps

module tb_top;
  import mpac_pkg::*;

  typedef struct {
    logic [31:0] sample;
    logic [7:0]  ch;
    logic        first;
    logic        last;
    logic [31:0] scale;
    logic        typed;   // expected result given in the row
    logic [31:0] avg;
  } pool_row_t;

  typedef struct {
    logic [31:0] avg;
    logic [7:0]  ch;
  } pool_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_OUTPUT_MIN;
  logic [WORD_W-1:0] cfg_data_i = '0;

  mpac_in_if  in_if ();
  mpac_out_if out_if ();

  multipass_average_pool_clamp_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0]  sums [256];
  bit           written [256];
  logic [31:0]  clamp_lo = NEG_INF;
  logic [31:0]  clamp_hi = POS_INF;
  pool_result_t avg_q [$];
  int           errors = 0;
  bit           calm = 1'b0;     // no idling on either side
  int           hold_req = 0;    // long receiver hold-off, in cycles
  int           cycles = 0;

  function automatic bit f_nan(input logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic bit f_inf(input logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] == 0;
  endfunction

  // round m * 2^e2 to binary32, nearest-even, subnormals kept
  function automatic logic [31:0] f_round(input logic s, input int e2, input logic [255:0] m);
    int msb, sh, ex;
    logic [255:0] q, rem, half;
    if (m == 0) return {s, 31'd0};
    msb = 0;
    for (int i = 0; i < 256; i++) if (m[i]) msb = i;
    sh = msb - 23;
    if (sh < -149 - e2) sh = -149 - e2;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh >= 250) begin
      q = '0;
    end else begin
      q = m >> sh;
      rem = m - (q << sh);
      half = 256'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end
    ex = e2 + sh;
    if (q[24]) begin
      q = q >> 1;
      ex++;
    end
    if (!q[23]) return {s, 8'd0, q[22:0]};
    if (ex + 150 >= 255) return {s, 8'hFF, 23'd0};
    return {s, 8'(ex + 150), q[22:0]};
  endfunction

  function automatic logic [23:0] f_mant(input logic [31:0] b);
    return (b[30:23] == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
  endfunction

  function automatic int f_exp(input logic [31:0] b);
    return (b[30:23] == 0) ? 1 : int'(b[30:23]);
  endfunction

  function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic [255:0] ma, mb, m;
    int d, e2;
    logic s;
    if (f_nan(a) || f_nan(b)) return QNAN;
    if (f_inf(a)) return (f_inf(b) && a[31] != b[31]) ? QNAN : a;
    if (f_inf(b)) return b;
    if (f_exp(b) > f_exp(a)) begin
      t = a; a = b; b = t;
    end
    d = f_exp(a) - f_exp(b);
    if (d > 60) begin
      // far smaller operand only matters as a sticky bit
      ma = 256'(f_mant(a)) << 60;
      mb = 256'(f_mant(b) != 0);
      e2 = f_exp(a) - 60 - 150;
    end else begin
      ma = 256'(f_mant(a)) << d;
      mb = 256'(f_mant(b));
      e2 = f_exp(b) - 150;
    end
    if (a[31] == b[31]) begin
      m = ma + mb; s = a[31];
    end else if (ma >= mb) begin
      m = ma - mb; s = (ma == mb) ? 1'b0 : a[31];
    end else begin
      m = mb - ma; s = b[31];
    end
    return f_round(s, e2, m);
  endfunction

  function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return QNAN;
    if (f_inf(a) || f_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return QNAN;
      return {s, 8'hFF, 23'd0};
    end
    return f_round(s, f_exp(a) + f_exp(b) - 300, 256'(f_mant(a)) * 256'(f_mant(b)));
  endfunction

  // ordered less-than, false on NaN, zeros equal
  function automatic bit f_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka, kb;
    if (f_nan(a) || f_nan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka < kb;
  endfunction

  // update the sum store, return 1 with the pooled value on a last row
  function automatic bit pool_word(input pool_row_t r, output logic [31:0] avg);
    logic [31:0] sum, v;
    sum = r.first ? r.sample : f_add(sums[r.ch], r.sample);
    sums[r.ch] = sum;
    written[r.ch] = 1'b1;
    avg = '0;
    if (!r.last) return 1'b0;
    v = f_mul(sum, r.scale);
    if (f_lt(v, clamp_lo)) v = clamp_lo;
    if (f_lt(clamp_hi, v)) v = clamp_hi;
    avg = f_nan(v) ? QNAN : v;
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] specials [8] = '{32'h0, 32'h8000_0000, POS_INF, NEG_INF, QNAN,
                                 32'h1, 32'h807F_FFFF, 32'h7F7F_FFFF};
    case ($urandom_range(0, 11))
      6:       return $urandom;
      7:       return specials[$urandom_range(0, 7)];
      8:       return {1'($urandom), 8'd0, 23'($urandom)};
      9:       return {1'($urandom), 8'($urandom_range(250, 254)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    endcase
  endfunction

  task automatic send(input pool_row_t r);
    logic [31:0] avg;
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 99) < 27) begin
        in_if.valid = 1'b0;
      end else begin
        in_if.valid = 1'b1;
        in_if.sample_bits = r.sample;
        in_if.channel_index = r.ch;
        in_if.first_row = r.first;
        in_if.last_row = r.last;
        in_if.scale_bits = r.scale;
        @(posedge clk_i);
        if (in_if.ready) begin
          done = 1'b1;
          if (pool_word(r, avg)) avg_q.push_back('{r.typed ? r.avg : avg, r.ch});
        end
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (avg_q.size() != 0) @(posedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_bounds(input logic [31:0] lo, input logic [31:0] hi);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = CFG_OUTPUT_MIN;
    cfg_data_i = lo;
    @(negedge clk_i);
    cfg_idx_i = CFG_OUTPUT_MAX;
    cfg_data_i = hi;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    clamp_lo = lo;
    clamp_hi = hi;
  endtask

  task automatic random_word();
    pool_row_t r;
    r.ch = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    r.first = !written[r.ch] || $urandom_range(0, 3) == 0;
    r.last = $urandom_range(0, 2) == 0;
    r.sample = rand_float();
    r.scale = ($urandom_range(0, 3) != 0) ? {1'b0, 8'($urandom_range(121, 127)), 23'($urandom)}
                                          : rand_float();
    r.typed = 1'b0;
    r.avg = '0;
    send(r);
  endtask

  // receiver: random stalls, or one long hold-off when asked
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_req > 0) begin
      out_if.ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else begin
      out_if.ready <= calm || $urandom_range(0, 99) >= 27;
    end
  end

  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (avg_q.size() == 0) begin
        $display("%0t: unexpected word avg=%h ch=%0d", $time, out_if.average_bits,
                 out_if.out_channel);
        errors++;
      end else begin
        want = avg_q.pop_front();
        if (out_if.average_bits !== want.avg) begin
          $display("%0t: average_bits expected %h actual %h", $time, want.avg,
                   out_if.average_bits);
          errors++;
        end
        if (out_if.out_channel !== want.ch) begin
          $display("%0t: out_channel expected %0d actual %0d", $time, want.ch,
                   out_if.out_channel);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  pool_row_t directed [16] = '{
    '{32'h3F80_0000, 8'd0,   1, 1, 32'h3F80_0000, 1, 32'h3F80_0000},
    '{POS_INF,       8'd1,   1, 1, 32'h3F80_0000, 1, POS_INF},
    '{NEG_INF,       8'd2,   1, 1, 32'h3F80_0000, 1, NEG_INF},
    '{32'h7FFF_FFFF, 8'd255, 1, 1, 32'h3F80_0000, 1, QNAN},
    '{32'hFFC0_0001, 8'd3,   1, 1, 32'h3F80_0000, 1, QNAN},
    '{POS_INF,       8'd4,   1, 1, 32'h0,         1, QNAN},   // inf times zero
    '{32'h0,         8'd5,   1, 1, 32'h8000_0000, 1, 32'h8000_0000},
    '{32'h7F7F_FFFF, 8'd6,   1, 0, 32'h0,         0, 32'h0},
    '{32'h7F7F_FFFF, 8'd6,   0, 1, 32'h3F80_0000, 1, POS_INF},   // sum overflows
    '{32'h1,         8'd7,   1, 0, 32'h0,         0, 32'h0},
    '{32'h1,         8'd7,   0, 1, 32'h3F80_0000, 1, 32'h2},   // subnormals kept
    '{32'h4000_0000, 8'd8,   1, 0, 32'h0,         0, 32'h0},
    '{32'h4040_0000, 8'd8,   0, 0, 32'h0,         0, 32'h0},
    '{32'h40E0_0000, 8'd8,   0, 1, 32'h3E80_0000, 0, 32'h0},
    '{NEG_INF,       8'd9,   1, 0, 32'h0,         0, 32'h0},
    '{POS_INF,       8'd9,   0, 1, 32'h3F80_0000, 1, QNAN}    // -inf plus +inf
  };

  logic [31:0] bound_sets [8][2] = '{
    '{32'h0,         32'h40C0_0000},
    '{32'hFFFF_FFFF, 32'h0},          // NaN lower bound
    '{32'h4000_0000, 32'h3F80_0000},  // min above max
    '{32'h0,         32'hFFFF_FFFF},
    '{QNAN,          32'hBF80_0000},
    '{32'hC2C8_0000, 32'h42C8_0000},
    '{32'h0,         32'h0},
    '{NEG_INF,       POS_INF}
  };

  initial begin
    in_if.valid = 1'b0;
    in_if.sample_bits = '0;
    in_if.channel_index = '0;
    in_if.first_row = 1'b0;
    in_if.last_row = 1'b0;
    in_if.scale_bits = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < 256; i++) begin
      sums[i] = '0;
      written[i] = 1'b0;
    end
    // falling reset edge so the asynchronous reset takes effect
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send(directed[i]);

    for (int p = 0; p < 10; p++) begin
      if (p < 8) set_bounds(bound_sets[p][0], bound_sets[p][1]);
      else set_bounds($urandom, $urandom);
      calm = (p == 1);
      for (int k = 0; k < 95; k++) begin
        if (p == 2 && k == 10) hold_req = 300;   // pipe fills, input stalls
        if (p == 4 && k == 40) drain();
        random_word();
      end
    end
    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mpac_pkg.sv
hdl/mpac_if.sv
hdl/mpac_ram.sv
hdl/mpac_accum.sv
hdl/mpac_scale.sv
hdl/multipass_average_pool_clamp_top.sv
hdl/mpac_checker.sv
sim/tb_top.sv
